// File: design/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared widths, register indexes, reset values and status codes for the
// pair contact repulsion force pipeline.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int POS_W  = 24;   // Q8.16 signed positions and forces
    localparam int LEN_W  = 24;   // Q8.16 unsigned lengths
    localparam int AGE_W  = 32;   // Q16.16 unsigned ages
    localparam int DIFF_W = 25;   // one axis difference, magnitude
    localparam int QUO_W  = 25;   // quotient and root width
    localparam int SQ_W   = 50;   // squares, sum of squares, spring products
    localparam int GP_W   = DIFF_W + AGE_W;

    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    localparam int DIMENSIONS_DEF = 3;

    localparam logic [IDX_W-1:0] CFG_STIFFNESS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_GROWTH    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DIV_REST  = 2'd2;

    localparam logic [LEN_W-1:0] STIFFNESS_RST = 24'd19661;
    localparam logic [AGE_W-1:0] GROWTH_RST    = 32'd65536;
    localparam logic [LEN_W-1:0] DIV_REST_RST  = 24'd32768;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_COINCIDENT = 2'd1;
    localparam logic [1:0] ST_APART      = 2'd2;

endpackage

// File: design/cpr_div.sv
// ----------------------------------------------------------------------------
// cpr_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QW bits; a side word travels with each item.
// ----------------------------------------------------------------------------
module cpr_div #(
    parameter int NW = 50,
    parameter int DW = 25,
    parameter int QW = 25,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [PW-1:0] side_out
);

    logic [DW:0]   rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [PW-1:0] side_reg [QW];
    logic          vld_reg  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW:0]   rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] side_w;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in = (DW+1)'(num >> QW);
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
            assign den_in = den;
            assign side_w = side_in;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
            assign side_w = side_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        assign trial = {rem_in[DW-1:0], low_in[QW-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= take ? (trial - {1'b0, den_in}) : trial;
            quo_reg[j]  <= {quo_in[QW-2:0], take};
            low_reg[j]  <= {low_in[QW-2:0], 1'b0};
            den_reg[j]  <= den_in;
            side_reg[j] <= side_w;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// File: design/cpr_sqrt.sv
// ----------------------------------------------------------------------------
// cpr_sqrt
// Pipelined integer square root, one root bit (two radicand bits) per stage.
// Gives floor(sqrt(rad)); a side word travels with each item.
// ----------------------------------------------------------------------------
module cpr_sqrt #(
    parameter int RW = 25,
    parameter int PW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad,
    input  logic [PW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [PW-1:0]   side_out
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [PW-1:0]   side_reg [RW];
    logic            vld_reg  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [2*RW-1:0] rad_in;
        logic [RW-1:0]   root_in;
        logic [PW-1:0]   side_w;
        logic            vld_in;
        logic [RW+3:0]   cur;
        logic [RW+3:0]   trial;
        logic            take;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = rad;
            assign root_in = '0;
            assign side_w  = side_in;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_w  = side_reg[j-1];
            assign vld_in  = vld_reg[j-1];
        end

        assign cur   = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= take ? (RW+2)'(cur - trial) : (RW+2)'(cur);
            root_reg[j] <= {root_in[RW-2:0], take};
            rad_reg[j]  <= {rad_in[2*RW-3:0], 2'b00};
            side_reg[j] <= side_w;
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

// File: design/pair_contact_repulsion_force.sv
// ----------------------------------------------------------------------------
// pair_contact_repulsion_force
// Linear spring contact force between two cell centres, with rest length
// growth for marked, newly divided pairs. Fully pipelined, one pair a cycle.
//
//   channel | ports                                       | handshake
//   --------+---------------------------------------------+----------------
//   input   | a_*, b_*, radius_*, age_*, pair_marked      | start & !busy
//   result  | force_x, force_y, force_z, status           | done (1 cycle)
//   config  | wr_index, wr_data                           | wr_en
//
// A pair accepted at one edge passes 3 * 25 stages of square root and two
// divider chains, plus 7 registers, before its result shows.
// A new pair may enter every cycle; busy stays low.
// Reset clears all valid bits and loads the register defaults.
// The receiver takes each result word in the cycle that done marks it.
// ----------------------------------------------------------------------------
module pair_contact_repulsion_force #(
    parameter int DIMENSIONS = cpr_pkg::DIMENSIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cpr_pkg::POS_W-1:0]  a_x,
    input  logic signed [cpr_pkg::POS_W-1:0]  a_y,
    input  logic signed [cpr_pkg::POS_W-1:0]  a_z,
    input  logic signed [cpr_pkg::POS_W-1:0]  b_x,
    input  logic signed [cpr_pkg::POS_W-1:0]  b_y,
    input  logic signed [cpr_pkg::POS_W-1:0]  b_z,
    input  logic        [cpr_pkg::LEN_W-1:0]  radius_a,
    input  logic        [cpr_pkg::LEN_W-1:0]  radius_b,
    input  logic        [cpr_pkg::AGE_W-1:0]  age_a,
    input  logic        [cpr_pkg::AGE_W-1:0]  age_b,
    input  logic                              pair_marked,
    input  logic                              wr_en,
    input  logic        [cpr_pkg::IDX_W-1:0]  wr_index,
    input  logic        [cpr_pkg::CFG_W-1:0]  wr_data,
    output logic                              done,
    output logic signed [cpr_pkg::POS_W-1:0]  force_x,
    output logic signed [cpr_pkg::POS_W-1:0]  force_y,
    output logic signed [cpr_pkg::POS_W-1:0]  force_z,
    output logic        [1:0]                 status
);

    localparam int DW  = cpr_pkg::DIFF_W;
    localparam int QW  = cpr_pkg::QUO_W;
    localparam int SW  = cpr_pkg::SQ_W;
    localparam int GW  = cpr_pkg::GP_W;
    localparam int LAT = 3 * QW + 7;
    localparam logic [DW-1:0] MAG_LIM = DW'(1) << (cpr_pkg::POS_W - 1);

    // Side word through the square root: magnitudes, signs, radius sum, growth
    localparam int SQ_PW = 3 * DW + 3 + DW + 1;
    // Side word through the spring divider: magnitudes, signs, distance, status
    localparam int M_PW  = 3 * DW + 3 + DW + 2;

    // ---------------- configuration registers ----------------
    logic [cpr_pkg::LEN_W-1:0] stiff_reg;
    logic [cpr_pkg::AGE_W-1:0] gdur_reg;
    logic [cpr_pkg::LEN_W-1:0] lam_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= cpr_pkg::STIFFNESS_RST;
            gdur_reg  <= cpr_pkg::GROWTH_RST;
            lam_reg   <= cpr_pkg::DIV_REST_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cpr_pkg::CFG_STIFFNESS: stiff_reg <= wr_data[cpr_pkg::LEN_W-1:0];
                cpr_pkg::CFG_GROWTH:    gdur_reg  <= wr_data[cpr_pkg::AGE_W-1:0];
                cpr_pkg::CFG_DIV_REST:  lam_reg   <= wr_data[cpr_pkg::LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    // The pipeline never holds off a pair.
    assign busy = 1'b0;

    // ---------------- stage 1: axis differences, rest length set-up ----------------
    logic [DW-1:0] ad1_next [3];
    logic          pos1_next [3];
    logic [DW-1:0] ad1_reg [3];
    logic          pos1_reg [3];
    logic [DW-1:0] sum1_reg, gdiff1_reg;
    logic          grow1_reg, gup1_reg, v1_reg;
    logic [cpr_pkg::AGE_W-1:0] age1_reg;

    logic signed [cpr_pkg::POS_W-1:0] pa [3];
    logic signed [cpr_pkg::POS_W-1:0] pb [3];
    logic [DW-1:0] sum1_next;

    assign pa[0] = a_x;
    assign pa[1] = a_y;
    assign pa[2] = a_z;
    assign pb[0] = b_x;
    assign pb[1] = b_y;
    assign pb[2] = b_z;
    assign sum1_next = DW'(radius_a) + DW'(radius_b);

    always_comb
    begin
        logic signed [DW-1:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d = DW'(pb[i]) - DW'(pa[i]);
            if (i >= DIMENSIONS)
            begin
                d = '0;
            end
            pos1_next[i] = !d[DW-1] && (d != '0);
            ad1_next[i]  = d[DW-1] ? DW'(-d) : DW'(d);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ad1_reg[i]  <= ad1_next[i];
            pos1_reg[i] <= pos1_next[i];
        end
        sum1_reg   <= sum1_next;
        grow1_reg  <= (age_a < gdur_reg) && (age_b < gdur_reg) && pair_marked;
        gup1_reg   <= (sum1_next >= DW'(lam_reg));
        gdiff1_reg <= (sum1_next >= DW'(lam_reg)) ? (sum1_next - DW'(lam_reg))
                                                  : (DW'(lam_reg) - sum1_next);
        age1_reg   <= age_a;
    end

    // ---------------- stage 2: squares, growth product ----------------
    logic [SW-1:0] sq2_reg [3];
    logic [DW-1:0] ad2_reg [3];
    logic          pos2_reg [3];
    logic [GW-1:0] gp2_reg;
    logic [DW-1:0] sum2_reg;
    logic          grow2_reg, gup2_reg, v2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i]  <= SW'(ad1_reg[i]) * SW'(ad1_reg[i]);
            ad2_reg[i]  <= ad1_reg[i];
            pos2_reg[i] <= pos1_reg[i];
        end
        gp2_reg   <= GW'(gdiff1_reg) * GW'(age1_reg);
        sum2_reg  <= sum1_reg;
        grow2_reg <= grow1_reg;
        gup2_reg  <= gup1_reg;
    end

    // ---------------- stage 3: sum of squares ----------------
    logic [SW-1:0] ssq3_reg;
    logic [DW-1:0] ad3_reg [3];
    logic          pos3_reg [3];
    logic [GW-1:0] gp3_reg;
    logic [DW-1:0] sum3_reg;
    logic          grow3_reg, gup3_reg, v3_reg;

    always_ff @(posedge clk)
    begin
        ssq3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            ad3_reg[i]  <= ad2_reg[i];
            pos3_reg[i] <= pos2_reg[i];
        end
        gp3_reg   <= gp2_reg;
        sum3_reg  <= sum2_reg;
        grow3_reg <= grow2_reg;
        gup3_reg  <= gup2_reg;
    end

    // ---------------- distance and grown rest length, side by side ----------------
    logic          sq_valid;
    logic [QW-1:0] dist_w;
    logic [SQ_PW-1:0] sq_side_out;
    logic          gq_valid;
    logic [QW-1:0] gq_w;
    logic          gq_up;

    cpr_sqrt #(
        .RW (QW),
        .PW (SQ_PW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .rad       (ssq3_reg),
        .side_in   ({ad3_reg[0], ad3_reg[1], ad3_reg[2],
                     pos3_reg[0], pos3_reg[1], pos3_reg[2], sum3_reg, grow3_reg}),
        .out_valid (sq_valid),
        .root      (dist_w),
        .side_out  (sq_side_out)
    );

    cpr_div #(
        .NW (GW),
        .DW (cpr_pkg::AGE_W),
        .QW (QW),
        .PW (1)
    ) u_div_grow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (gp3_reg),
        .den       (gdur_reg),
        .side_in   (gup3_reg),
        .out_valid (gq_valid),
        .quo       (gq_w),
        .side_out  (gq_up)
    );

    // ---------------- stage 4: rest length, status ----------------
    logic [DW-1:0] ad_s [3];
    logic          pos_s [3];
    logic [DW-1:0] sum_s, rest4_next;
    logic          grow_s;
    logic [1:0]    st4_next;

    assign {ad_s[0], ad_s[1], ad_s[2], pos_s[0], pos_s[1], pos_s[2], sum_s, grow_s}
        = sq_side_out;

    always_comb
    begin
        if (!grow_s)
        begin
            rest4_next = sum_s;
        end
        else if (gq_up)
        begin
            rest4_next = DW'(lam_reg) + gq_w;
        end
        else
        begin
            rest4_next = DW'(lam_reg) - gq_w;
        end

        if (dist_w == '0)
        begin
            st4_next = cpr_pkg::ST_COINCIDENT;
        end
        else if (dist_w > rest4_next)
        begin
            st4_next = cpr_pkg::ST_APART;
        end
        else
        begin
            st4_next = cpr_pkg::ST_OK;
        end
    end

    logic [DW-1:0] rest4_reg, dist4_reg, rd4_reg;
    logic [DW-1:0] ad4_reg [3];
    logic          pos4_reg [3];
    logic [1:0]    st4_reg;
    logic          v4_reg;

    always_ff @(posedge clk)
    begin
        rest4_reg <= rest4_next;
        dist4_reg <= dist_w;
        rd4_reg   <= rest4_next - dist_w;
        st4_reg   <= st4_next;
        for (int i = 0; i < 3; i++)
        begin
            ad4_reg[i]  <= ad_s[i];
            pos4_reg[i] <= pos_s[i];
        end
    end

    // ---------------- stage 5: spring numerator 2 * k * (rest - dist) ----------------
    logic [SW-1:0] sp5_reg;
    logic [DW-1:0] rest5_reg, dist5_reg;
    logic [DW-1:0] ad5_reg [3];
    logic          pos5_reg [3];
    logic [1:0]    st5_reg;
    logic          v5_reg;

    always_ff @(posedge clk)
    begin
        sp5_reg   <= {(SW-1)'(stiff_reg) * (SW-1)'(rd4_reg), 1'b0};
        rest5_reg <= rest4_reg;
        dist5_reg <= dist4_reg;
        st5_reg   <= st4_reg;
        for (int i = 0; i < 3; i++)
        begin
            ad5_reg[i]  <= ad4_reg[i];
            pos5_reg[i] <= pos4_reg[i];
        end
    end

    logic           m_valid;
    logic [QW-1:0]  m_w;
    logic [M_PW-1:0] m_side_out;

    // The spring magnitude is at most 2 * k, which fits the 25-bit quotient.
    cpr_div #(
        .NW (SW),
        .DW (DW),
        .QW (QW),
        .PW (M_PW)
    ) u_div_spring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (sp5_reg),
        .den       (rest5_reg),
        .side_in   ({ad5_reg[0], ad5_reg[1], ad5_reg[2],
                     pos5_reg[0], pos5_reg[1], pos5_reg[2], dist5_reg, st5_reg}),
        .out_valid (m_valid),
        .quo       (m_w),
        .side_out  (m_side_out)
    );

    // ---------------- stage 6: per axis m * |d| ----------------
    logic [DW-1:0] ad_m [3];
    logic          pos_m [3];
    logic [DW-1:0] dist_m;
    logic [1:0]    st_m;

    assign {ad_m[0], ad_m[1], ad_m[2], pos_m[0], pos_m[1], pos_m[2], dist_m, st_m}
        = m_side_out;

    logic [SW-1:0] mp6_reg [3];
    logic          pos6_reg [3];
    logic [DW-1:0] dist6_reg;
    logic [1:0]    st6_reg;
    logic          v6_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mp6_reg[i]  <= SW'(m_w) * SW'(ad_m[i]);
            pos6_reg[i] <= pos_m[i];
        end
        dist6_reg <= dist_m;
        st6_reg   <= st_m;
    end

    // ---------------- axis dividers: |force| = m * |d| / dist ----------------
    logic          ax_valid;
    logic [QW-1:0] mag_w [3];
    logic          pos_o [3];
    logic [1:0]    st_o;

    cpr_div #(
        .NW (SW),
        .DW (DW),
        .QW (QW),
        .PW (3)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (mp6_reg[0]),
        .den       (dist6_reg),
        .side_in   ({pos6_reg[0], st6_reg}),
        .out_valid (ax_valid),
        .quo       (mag_w[0]),
        .side_out  ({pos_o[0], st_o})
    );

    for (genvar k = 1; k < 3; k++) begin : g_axis
        logic unused_valid;
        cpr_div #(
            .NW (SW),
            .DW (DW),
            .QW (QW),
            .PW (1)
        ) u_div_axis (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v6_reg),
            .num       (mp6_reg[k]),
            .den       (dist6_reg),
            .side_in   (pos6_reg[k]),
            .out_valid (unused_valid),
            .quo       (mag_w[k]),
            .side_out  (pos_o[k])
        );
    end

    // Axes beyond the configured dimension carry no force.
    function automatic logic g_axis_dummy(input int idx);
        return (idx >= DIMENSIONS);
    endfunction

    // ---------------- output: sign, saturate, zero on a special case ----------------
    logic signed [cpr_pkg::POS_W-1:0] f_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (st_o != cpr_pkg::ST_OK || g_axis_dummy(i))
            begin
                f_next[i] = '0;
            end
            else if (pos_o[i])
            begin
                f_next[i] = (mag_w[i] >= MAG_LIM) ? {1'b1, {(cpr_pkg::POS_W-1){1'b0}}}
                                                 : cpr_pkg::POS_W'(-mag_w[i]);
            end
            else
            begin
                f_next[i] = (mag_w[i] >= MAG_LIM) ? {1'b0, {(cpr_pkg::POS_W-1){1'b1}}}
                                                 : mag_w[i][cpr_pkg::POS_W-1:0];
            end
        end
    end

    logic done_reg;
    logic signed [cpr_pkg::POS_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [1:0] status_reg;

    always_ff @(posedge clk)
    begin
        fx_reg     <= f_next[0];
        fy_reg     <= f_next[1];
        fz_reg     <= f_next[2];
        status_reg <= st_o;
    end

    // Advance the valid bits with the data; the pipeline never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= sq_valid && gq_valid;
            v5_reg   <= v4_reg;
            v6_reg   <= m_valid;
            done_reg <= ax_valid;
        end
    end

    assign done    = done_reg;
    assign force_x = fx_reg;
    assign force_y = fy_reg;
    assign force_z = fz_reg;
    assign status  = status_reg;

`ifndef SYNTHESIS
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != cpr_pkg::ST_OK) |-> (force_x == '0) && (force_y == '0)
                                             && (force_z == '0))
        else $error("force not zero on a special case");

    a_unused_axis: assert property (@(posedge clk) disable iff (!rst_n)
        done && (DIMENSIONS < 3) |-> (force_z == '0))
        else $error("force on an unused axis");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without a pair accepted earlier");

    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid == gq_valid)
        else $error("distance and rest length out of step");
`endif

endmodule

// File: tb/tb_pair_contact_repulsion_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pair_contact_repulsion_force
// Self-checking bench for the pair contact repulsion force pipeline. Directed
// corner pairs, then mostly overlapping random pairs under several register
// settings. Every result word is checked against a bit-exact force predictor.
// ----------------------------------------------------------------------------
module tb_pair_contact_repulsion_force;

    localparam int POS_W = cpr_pkg::POS_W;
    localparam int LEN_W = cpr_pkg::LEN_W;
    localparam int AGE_W = cpr_pkg::AGE_W;
    localparam int IDX_W = cpr_pkg::IDX_W;
    localparam int CFG_W = cpr_pkg::CFG_W;

    localparam logic [IDX_W-1:0] CFG_STIFFNESS = cpr_pkg::CFG_STIFFNESS;
    localparam logic [IDX_W-1:0] CFG_GROWTH    = cpr_pkg::CFG_GROWTH;
    localparam logic [IDX_W-1:0] CFG_DIV_REST  = cpr_pkg::CFG_DIV_REST;

    localparam logic [1:0] ST_OK         = cpr_pkg::ST_OK;
    localparam logic [1:0] ST_COINCIDENT = cpr_pkg::ST_COINCIDENT;
    localparam logic [1:0] ST_APART      = cpr_pkg::ST_APART;

    localparam int DIMS      = cpr_pkg::DIMENSIONS_DEF;
    localparam int LATENCY   = 82;
    localparam int SETTLE    = LATENCY + 10;
    localparam int STALL_MAX = 2000;

    typedef struct {
        logic signed [POS_W-1:0] pa [3];
        logic signed [POS_W-1:0] pb [3];
        logic [LEN_W-1:0]        ra;
        logic [LEN_W-1:0]        rb;
        logic [AGE_W-1:0]        age_a;
        logic [AGE_W-1:0]        age_b;
        logic                    marked;
    } pair_t;

    typedef struct {
        logic signed [POS_W-1:0] f [3];
        logic [1:0]              st;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [POS_W-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [POS_W-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic [LEN_W-1:0] radius_a = '0, radius_b = '0;
    logic [AGE_W-1:0] age_a = '0, age_b = '0;
    logic pair_marked = 1'b0;
    logic wr_en = 1'b0;
    logic [IDX_W-1:0] wr_index = '0;
    logic [CFG_W-1:0] wr_data = '0;
    logic done;
    logic signed [POS_W-1:0] force_x, force_y, force_z;
    logic [1:0] status;

    // shadow copy of the block's registers
    logic [LEN_W-1:0] stiff_reg  = cpr_pkg::STIFFNESS_RST;
    logic [AGE_W-1:0] growth_reg = cpr_pkg::GROWTH_RST;
    logic [LEN_W-1:0] lam_reg    = cpr_pkg::DIV_REST_RST;

    pair_t  pair_q [$];
    force_t force_q [$];
    pair_t  cur_pair;
    logic   word_taken = 1'b0;
    logic   calm = 1'b0;      // no random gaps while set
    int     errors = 0;
    int     stall_cnt = 0;

    pair_contact_repulsion_force dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .radius_a(radius_a), .radius_b(radius_b), .age_a(age_a), .age_b(age_b),
        .pair_marked(pair_marked), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .done(done), .force_x(force_x), .force_y(force_y),
        .force_z(force_z), .status(status)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Force on A for one pair under the current shadow registers.
    function automatic force_t predict_force(pair_t p);
        force_t res;
        longint d [3];
        longint unsigned mag_d [3];
        longint unsigned sumsq, dist_len, rest, span, m, mag;
        longint f;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 0;
            if (i < DIMS) d[i] = longint'(p.pb[i]) - longint'(p.pa[i]);
            mag_d[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            sumsq += mag_d[i] * mag_d[i];
            res.f[i] = '0;
        end
        dist_len = int_root(sumsq);
        rest = longint'(p.ra) + longint'(p.rb);
        // grow the rest length only for young marked pairs
        if (p.age_a < growth_reg && p.age_b < growth_reg && p.marked) begin
            if (rest >= lam_reg) begin
                span = rest - lam_reg;
                rest = lam_reg + (span * p.age_a) / growth_reg;
            end else begin
                span = lam_reg - rest;
                rest = lam_reg - (span * p.age_a) / growth_reg;
            end
        end
        if (dist_len == 0) begin
            res.st = ST_COINCIDENT;
            return res;
        end
        if (dist_len > rest) begin
            res.st = ST_APART;
            return res;
        end
        m = (2 * longint'(stiff_reg) * (rest - dist_len)) / rest;
        if (m > (64'd1 << 38) - 1) m = (64'd1 << 38) - 1;
        for (int i = 0; i < DIMS; i++) begin
            mag = (m * mag_d[i]) / dist_len;
            if (mag > 64'd8388608) mag = 64'd8388608;
            f = (d[i] > 0) ? -longint'(mag) : longint'(mag);
            if (f > 8388607) f = 8388607;
            res.f[i] = f[POS_W-1:0];
        end
        res.st = ST_OK;
        return res;
    endfunction

    function automatic pair_t mk_pair(int ax, int ay, int az, int bx, int by, int bz,
                                      int unsigned ra, int unsigned rb,
                                      int unsigned ga, int unsigned gb, bit mk);
        pair_t p;
        p.pa[0] = POS_W'(ax); p.pa[1] = POS_W'(ay); p.pa[2] = POS_W'(az);
        p.pb[0] = POS_W'(bx); p.pb[1] = POS_W'(by); p.pb[2] = POS_W'(bz);
        p.ra = LEN_W'(ra); p.rb = LEN_W'(rb);
        p.age_a = ga; p.age_b = gb; p.marked = mk;
        return p;
    endfunction

    function automatic logic [AGE_W-1:0] rand_age();
        if (growth_reg > 1 && $urandom_range(1) == 1) return $urandom_range(growth_reg - 1, 0);
        return $urandom();
    endfunction

    // Random pair: mostly overlapping cells, some coincident, apart and raw noise.
    function automatic pair_t rand_pair();
        pair_t p;
        int kind;
        int unsigned reach;
        kind = $urandom_range(99);
        p.ra = LEN_W'($urandom_range(24'h3FFFF, 1));
        p.rb = LEN_W'($urandom_range(24'h3FFFF, 1));
        p.age_a = rand_age();
        p.age_b = rand_age();
        p.marked = 1'($urandom_range(1));
        reach = (p.ra + p.rb) / 2;
        for (int i = 0; i < 3; i++) begin
            p.pa[i] = POS_W'(int'($urandom_range(24'hC00000)) - 24'h600000);
            if (kind < 14)
                p.pb[i] = p.pa[i];
            else if (kind < 24)
                p.pb[i] = POS_W'(p.pa[i] + int'($urandom_range(24'h100000, 24'h80000)));
            else
                p.pb[i] = POS_W'(p.pa[i] + int'($urandom_range(2 * reach)) - int'(reach));
        end
        if (kind < 8) begin
            for (int i = 0; i < 3; i++) begin
                p.pa[i] = POS_W'($urandom());
                p.pb[i] = POS_W'($urandom());
            end
            p.ra = LEN_W'($urandom());
            p.rb = LEN_W'($urandom());
            p.age_a = $urandom();
            p.age_b = $urandom();
        end
        return p;
    endfunction

    // Record each accepted word and its expected force.
    always @(posedge clk) begin
        word_taken <= start && !busy;
        if (rst_n && start && !busy) force_q.push_back(predict_force(cur_pair));
    end

    // Check each result word against the oldest expectation.
    always @(posedge clk) begin
        force_t want;
        logic signed [POS_W-1:0] got [3];
        if (rst_n && done) begin
            got[0] = force_x; got[1] = force_y; got[2] = force_z;
            if (force_q.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end else begin
                want = force_q.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got[i] !== want.f[i]) begin
                        $display("%0t: force[%0d] expected %0d got %0d",
                                 $time, i, want.f[i], got[i]);
                        errors++;
                    end
                if (status !== want.st) begin
                    $display("%0t: status expected %0d got %0d", $time, want.st, status);
                    errors++;
                end
            end
        end
    end

    // Feed pairs at the falling edge; hold a word until it is taken.
    always @(negedge clk) begin
        if (rst_n && (!start || word_taken)) begin
            if (pair_q.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
                cur_pair = pair_q.pop_front();
                a_x <= cur_pair.pa[0]; a_y <= cur_pair.pa[1]; a_z <= cur_pair.pa[2];
                b_x <= cur_pair.pb[0]; b_y <= cur_pair.pb[1]; b_z <= cur_pair.pb[2];
                radius_a <= cur_pair.ra;
                radius_b <= cur_pair.rb;
                age_a <= cur_pair.age_a;
                age_b <= cur_pair.age_b;
                pair_marked <= cur_pair.marked;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk) begin
        if ((start && !busy) || done) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Wait until every pair is sent and answered, then let the pipe empty.
    task automatic drain();
        while (pair_q.size() > 0 || start || force_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        if (idx == CFG_STIFFNESS) stiff_reg = val[LEN_W-1:0];
        else if (idx == CFG_GROWTH) growth_reg = val;
        else if (idx == CFG_DIV_REST) lam_reg = val[LEN_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_random(int n);
        repeat (n) pair_q.push_back(rand_pair());
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners under reset values
        pair_q.push_back(mk_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                                 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 0, 1));
        pair_q.push_back(mk_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                                 24'hFFFFFF, 24'hFFFFFF, 0, 32'hFFFFFFFF, 0));
        pair_q.push_back(mk_pair(100, -200, 300, 100, -200, 300, 65536, 65536, 0, 0, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 1, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 0, -1, 0, 24'hFFFFFF, 0, 0, 0, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 40000, 65536, 65536, 16384, 1000, 1));
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 40000, 65536, 65536, 16384, 65536, 1));
        pair_q.push_back(mk_pair(0, 0, 0, 20000, 0, 0, 4000, 4000, 32768, 0, 1));
        pair_q.push_back(mk_pair(0, 0, 0, 20000, 0, 0, 4000, 4000, 65535, 65535, 1));
        pair_q.push_back(mk_pair(0, 0, 0, 131072, 0, 0, 65536, 65536, 0, 0, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 131073, 0, 0, 65536, 65536, 0, 0, 0));
        pair_q.push_back(mk_pair(-500, 700, -900, 500, -700, 900, 70000, 50000, 0, 0, 1));
        pair_q.push_back(mk_pair(5, 5, 5, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 1));
        load_random(280);
        drain();

        // strongest spring, shortest growth, zero start length; no gaps
        write_reg(CFG_STIFFNESS, 32'h00FFFFFF);
        write_reg(CFG_GROWTH, 32'd1);
        write_reg(CFG_DIV_REST, 32'd0);
        calm = 1'b1;
        pair_q.push_back(mk_pair(0, 0, 0, 1, 1, 1, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 1));
        load_random(300);
        drain();
        calm = 1'b0;

        // no spring, longest growth, longest start length
        write_reg(CFG_STIFFNESS, 32'd0);
        write_reg(CFG_GROWTH, 32'hFFFFFFFF);
        write_reg(CFG_DIV_REST, 32'h00FFFFFF);
        load_random(300);
        drain();

        // growth duration zero never grows the rest length
        write_reg(CFG_STIFFNESS, 32'd65536);
        write_reg(CFG_GROWTH, 32'd0);
        write_reg(CFG_DIV_REST, 32'd100000);
        load_random(250);
        drain();

        // random mid-range settings
        write_reg(CFG_STIFFNESS, $urandom_range(24'hFFFFFF));
        write_reg(CFG_GROWTH, $urandom_range(32'h00100000, 32'h00008000));
        write_reg(CFG_DIV_REST, $urandom_range(24'h3FFFF));
        load_random(370);
        drain();

        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
